[hw/rtl/kli_pkg.sv]
// Package for the keyframe linear interpolator: constants, payload types,
// command codes and the sequencer state type. Depends on nothing.
package kli_pkg;

  localparam int KLI_MAX_KEYS  = 64;
  localparam int KLI_FRAC_BITS = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [2:0][31:0] vec_t;

  typedef logic [6:0] cfg_item_t;

  typedef struct packed {
    logic               cmd;
    logic        [5:0]  key_index;
    logic signed [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic signed [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [5:0]  segment;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T0,
    S_SCAN,
    S_KEY,
    S_KEYCAP,
    S_VA,
    S_VB,
    S_VC,
    S_DIVW,
    S_MUL,
    S_ACC,
    S_DONE
  } state_t;

endpackage

[hw/rtl/kli_chan_if.sv]
// Valid/ready channel interface used for input, result and configuration.
// The payload type is a parameter; no dependencies.
interface kli_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/keyframe_linear_interpolator.sv]
// Keyframe linear interpolator: holds a table of keyframes (time plus x/y/z
// vector, signed Q16.16) in two single-port-read memories and answers
// queries with the linearly blended vector. A write transaction (cmd 0)
// stores one entry; indexes at or above MAX_KEYS are dropped. A query
// transaction (cmd 1) walks the intervals from key 0 upward, one key time
// per cycle from the time memory, until it finds its interval. Then the
// bit-serial fraction divider runs (the two key vector reads overlap it),
// then the three blend multiplies (one shared multiplier, add in the
// following cycle), then the result register is loaded. A query at or
// before the first key, or past the last key, skips divider and blend. The
// last cycle repeats while the output register is full and the receiver
// stalls. The result sits in an output register, so a new transaction is
// taken as soon as the sequencer is idle, even while the previous result
// waits. key_count (7 bits, reset 1) is written over the configuration
// channel; the user must write it only while no query is in flight, the
// block itself does not enforce this. 0 acts as 1 and values above MAX_KEYS
// act as MAX_KEYS. The memories have no reset: read only entries that
// were written. Depends on kli_pkg, kli_chan_if, kli_ram and kli_div.
module keyframe_linear_interpolator #(
  parameter int MAX_KEYS  = kli_pkg::KLI_MAX_KEYS,
  parameter int FRAC_BITS = kli_pkg::KLI_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  kli_chan_if.sink   in_ch,
  kli_chan_if.source out_ch,
  kli_chan_if.sink   cfg_ch
);

  import kli_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int PW = FRAC_BITS + 35;

  // Control state
  state_t    state_r, state_nxt;
  logic [6:0] key_count_r;
  logic      out_valid_r;

  // Datapath registers
  logic        [6:0]  n_r;
  logic        [6:0]  idx_r;
  logic signed [31:0] q_r;
  logic signed [31:0] tprev_r;
  logic               zero_len_r;
  vec_t               va_r, vb_r, res_r;
  logic        [5:0]  seg_r;
  logic        [1:0]  comp_r;
  logic signed [PW-1:0] prod_r;
  out_item_t          out_data_r;

  // Memory ports
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] t_raddr, v_raddr;
  logic [31:0]   t_rdata;
  logic [95:0]   v_rdata;
  logic signed [31:0] t_rd;

  // Divider
  logic               div_start, div_busy;
  logic [FRAC_BITS:0] div_quot;
  logic [31:0]        div_num, div_den;

  logic in_acc, is_query, hit, scan_end, out_load;
  logic [6:0] n_clamped;
  logic [FRAC_BITS:0] frac;
  logic signed [32:0] diff_c;
  logic signed [FRAC_BITS+1:0] frac_s;
  logic signed [PW-1:0] a_ext, blend_sum;
  logic [31:0] a_c, b_c;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_query = in_ch.data.cmd == CMD_QUERY;
  assign t_rd     = $signed(t_rdata);

  assign n_clamped = (key_count_r == 7'd0) ? 7'd1 :
                     (32'(key_count_r) > 32'(MAX_KEYS)) ? 7'(MAX_KEYS) : key_count_r;

  // Interval test against the key time just read
  assign hit      = (tprev_r <= q_r) && (q_r <= t_rd);
  assign scan_end = ({1'b0, idx_r} + 8'd2) >= {1'b0, n_r};
  assign out_load = !out_valid_r || out_ch.ready;

  // Both differences are non-negative when the interval holds the time.
  assign div_num = 32'(33'($signed({q_r[31], q_r}) - $signed({tprev_r[31], tprev_r})));
  assign div_den = 32'(33'($signed({t_rd[31], t_rd}) - $signed({tprev_r[31], tprev_r})));

  // Memories: key times and key vectors, written together
  assign waddr = AW'(in_ch.data.key_index);

  kli_ram #(
    .WIDTH (32),
    .DEPTH (MAX_KEYS)
  ) u_time_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (in_ch.data.key_time),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  kli_ram #(
    .WIDTH ($bits(vec_t)),
    .DEPTH (MAX_KEYS)
  ) u_value_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata ({in_ch.data.key_z, in_ch.data.key_y, in_ch.data.key_x}),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  kli_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt = S_T0;
        end
      end
      S_T0: begin
        if ((n_r == 7'd1) || (q_r <= t_rd)) begin
          state_nxt = S_KEY;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_VA;
        end else if (scan_end) begin
          state_nxt = S_KEY;
        end
      end
      S_KEY:    state_nxt = S_KEYCAP;
      S_KEYCAP: state_nxt = S_DONE;
      S_VA:     state_nxt = S_VB;
      S_VB:     state_nxt = S_VC;
      S_VC:     state_nxt = S_DIVW;
      S_DIVW: begin
        if (!div_busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (comp_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, memory addresses, divider start
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    t_raddr     = '0;
    v_raddr     = AW'(idx_r);
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        mem_we      = in_acc && !is_query &&
                      (32'(in_ch.data.key_index) < 32'(MAX_KEYS));
      end
      S_T0:   t_raddr = AW'(1);
      S_SCAN: begin
        t_raddr   = AW'(idx_r + 7'd2);
        div_start = hit;
      end
      S_VB:   v_raddr = AW'(idx_r + 7'd1);
      default: begin
      end
    endcase
  end

  assign cfg_ch.ready = 1'b1;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        key_count_r <= cfg_ch.data;
      end
      if ((state_r == S_DONE) && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Blend: a + floor((b - a) * frac / 2^FRAC_BITS), one component per pass
  assign frac      = zero_len_r ? '0 : div_quot;
  assign a_c       = va_r[comp_r];
  assign b_c       = vb_r[comp_r];
  assign diff_c    = $signed({b_c[31], b_c}) - $signed({a_c[31], a_c});
  assign frac_s    = $signed({1'b0, frac});
  assign a_ext     = $signed({{(PW-32){a_c[31]}}, a_c});
  assign blend_sum = a_ext + (prod_r >>> FRAC_BITS);

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && is_query) begin
          q_r <= in_ch.data.query_time;
          n_r <= n_clamped;
        end
      end
      S_T0: begin
        tprev_r <= t_rd;
        idx_r   <= 7'd0;
      end
      S_SCAN: begin
        if (hit) begin
          zero_len_r <= t_rd == tprev_r;
        end else if (scan_end) begin
          idx_r <= n_r - 7'd1;
        end else begin
          tprev_r <= t_rd;
          idx_r   <= idx_r + 7'd1;
        end
      end
      S_KEYCAP: begin
        res_r <= v_rdata;
        seg_r <= 6'(idx_r);
      end
      S_VB: va_r <= v_rdata;
      S_VC: begin
        vb_r  <= v_rdata;
        seg_r <= 6'(idx_r);
      end
      S_DIVW: comp_r <= 2'd0;
      S_MUL:  prod_r <= diff_c * frac_s;
      S_ACC: begin
        res_r[comp_r] <= blend_sum[31:0];
        comp_r        <= comp_r + 2'd1;
      end
      S_DONE: begin
        if (out_load) begin
          out_data_r.out_x   <= res_r[0];
          out_data_r.out_y   <= res_r[1];
          out_data_r.out_z   <= res_r[2];
          out_data_r.segment <= seg_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

[hw/rtl/kli_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/kli_div.sv]
// Bit-serial restoring divider for the blend fraction: (num << FRAC_BITS) / den,
// with num <= den, one quotient bit per cycle. Uses no package items.
module kli_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        num,
  input  logic [31:0]        den,
  output logic               busy,
  output logic [FRAC_BITS:0] quot
);

  localparam int CNTW = $clog2(FRAC_BITS + 1);

  logic              busy_r;
  logic [CNTW-1:0]   cnt_r;
  logic [32:0]       rem_r;
  logic [31:0]       den_r;
  logic [FRAC_BITS:0] quot_r;

  logic [32:0] trial;
  logic        ge;

  // First step tests the integer bit without a shift.
  assign trial = (cnt_r == '0) ? rem_r : {rem_r[31:0], 1'b0};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == CNTW'(FRAC_BITS))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? (trial - {1'b0, den_r}) : trial;
      quot_r <= {quot_r[FRAC_BITS-1:0], ge};
      cnt_r  <= cnt_r + CNTW'(1);
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule
